/* rtl/core/qau_pkg.sv */
// Shared definitions for the quaternion accumulate unit: function codes,
// sequencer states, the multiplier control group and the Hamilton product term tables.
// Used by every module under rtl/core; depends on nothing else.
package qau_pkg;

  // Width of the unit tolerance register.
  localparam int TOL_W = 14;

  // Byte address of the unit tolerance register.
  localparam logic [2:0] REG_UNIT_TOL = 3'd0;

  typedef enum logic [2:0] {
    F_LOAD  = 3'd0,
    F_IDENT = 3'd1,
    F_CONJ  = 3'd2,
    F_MUL_R = 3'd3,
    F_MUL_L = 3'd4,
    F_NORM  = 3'd5
  } func_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_MUL_GO,
    S_MUL_WAIT,
    S_SQ_GO,
    S_SQ_WAIT,
    S_SQRT_GO,
    S_SQRT_WAIT,
    S_CHECK,
    S_DIV_GO,
    S_DIV_WAIT,
    S_FIN
  } state_t;

  // Control group for the serial multiply-accumulate unit.
  typedef struct packed {
    logic start;
    logic clear;
    logic neg;
  } mul_ctl_t;

  // Hamilton product r = a * b, indexed by {component, term}; order x, y, z, w.
  localparam logic [1:0] HAM_A [16] = '{
    2'd3, 2'd0, 2'd1, 2'd2,
    2'd3, 2'd1, 2'd2, 2'd0,
    2'd3, 2'd2, 2'd0, 2'd1,
    2'd3, 2'd0, 2'd1, 2'd2
  };
  localparam logic [1:0] HAM_B [16] = '{
    2'd0, 2'd3, 2'd2, 2'd1,
    2'd1, 2'd3, 2'd0, 2'd2,
    2'd2, 2'd3, 2'd1, 2'd0,
    2'd3, 2'd0, 2'd1, 2'd2
  };
  // Bit {component, term} set where the term enters with a minus sign.
  localparam logic [15:0] HAM_NEG = 16'b1110_1000_1000_1000;

endpackage

/* rtl/core/qau_mul_acc.sv */
// Bit-serial shift-and-add multiplier that accumulates signed products.
// One multiplier bit per cycle; uses qau_pkg for the control group.
module qau_mul_acc
  import qau_pkg::*;
#(
  parameter int MW = 16,
  parameter int AW = 34
) (
  input  logic           clk,
  input  logic           rst,
  input  mul_ctl_t       ctl,
  input  logic [MW-1:0]  ma,
  input  logic [MW-1:0]  mb,
  output logic           done,
  output logic [AW-1:0]  acc
);

  localparam int CW = $clog2(MW + 1);

  logic [AW-1:0] ma_sh;
  logic [MW-1:0] mb_sh;
  logic          neg_r;
  logic          busy;
  logic [CW-1:0] cnt;
  logic [AW-1:0] addend;

  // The shifted multiplicand enters with the sign of the whole product.
  assign addend = neg_r ? (~ma_sh + 1'b1) : ma_sh;

  // Sequencing of the multiplier bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= CW'(MW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Operand shift registers and the accumulator.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      ma_sh <= AW'(ma);
      mb_sh <= mb;
      neg_r <= ctl.neg;
    end else if (busy) begin
      ma_sh <= ma_sh << 1;
      mb_sh <= mb_sh >> 1;
    end
    if (ctl.clear) begin
      acc <= '0;
    end else if (busy && mb_sh[0]) begin
      acc <= acc + addend;
    end
  end

endmodule

/* rtl/core/qau_sqrt.sv */
// Bit-serial integer square root, two radicand bits and one root bit per cycle.
// Gives the floor of the root; uses qau_pkg only by convention.
module qau_sqrt
  import qau_pkg::*;
#(
  parameter int RW = 34
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [RW-1:0]     radicand,
  output logic              done,
  output logic [RW/2-1:0]   root
);

  localparam int HW = RW / 2;
  localparam int CW = $clog2(HW + 1);

  logic [RW-1:0] rad;
  logic [HW+1:0] rem;
  logic          busy;
  logic [CW-1:0] cnt;
  logic [HW+2:0] trial_in;
  logic [HW+2:0] trial;
  logic [HW+2:0] diff;
  logic          fits;

  // Bring down two bits and try the next root bit.
  assign trial_in = {rem[HW:0], rad[RW-1 -: 2]};
  assign trial    = {1'b0, root, 2'b01};
  assign diff     = trial_in - trial;
  assign fits     = (trial_in >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(HW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder and root registers.
  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= rad << 2;
      rem  <= fits ? diff[HW+1:0] : trial_in[HW+1:0];
      root <= {root[HW-2:0], fits};
    end
  end

endmodule

/* rtl/core/qau_div.sv */
// Bit-serial restoring divider for unsigned values, one quotient bit per cycle.
// The divisor must be nonzero; uses qau_pkg only by convention.
module qau_div
  import qau_pkg::*;
#(
  parameter int NW = 31,
  parameter int DW = 17
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [NW-1:0]  num,
  input  logic [DW-1:0]  den,
  output logic           done,
  output logic [NW-1:0]  quot
);

  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] den_r;
  logic [DW-1:0] rem;
  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW:0]   part;
  logic [DW:0]   diff;
  logic          fits;

  // Shift in the next numerator bit and subtract where the divisor fits.
  assign part = {rem, quot[NW-1]};
  assign diff = part - {1'b0, den_r};
  assign fits = (part >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The quotient register holds the numerator and fills with quotient bits.
  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      rem   <= '0;
      quot  <= num;
    end else if (busy) begin
      rem  <= fits ? diff[DW-1:0] : part[DW-1:0];
      quot <= {quot[NW-2:0], fits};
    end
  end

endmodule

/* rtl/core/quaternion_accumulate_unit.sv */
// Quaternion accumulator: keeps one quaternion in fixed point and applies load, identity,
// conjugate, right or left Hamilton product and normalize; uses qau_pkg and the serial units.
//
// One request is processed at a time. Load, identity, conjugate and unused codes form their
// result in the execute state. A product runs 16 serial multiplies through the shift-add
// unit (MW = max(COMP_WIDTH, 16)). Normalize takes four serial squares, a square root and
// four restoring divisions; a normalize that is skipped ends after the square root.
// A finished result waits in the output register; the next request is taken once the
// result has been moved there.
module quaternion_accumulate_unit
  import qau_pkg::*;
#(
  parameter int FRAC_BITS  = 14,
  parameter int COMP_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         func,
  input  logic signed [15:0] in_x,
  input  logic signed [15:0] in_y,
  input  logic signed [15:0] in_z,
  input  logic signed [15:0] in_w,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_x,
  output logic signed [15:0] out_y,
  output logic signed [15:0] out_z,
  output logic signed [15:0] out_w,
  output logic               saturated,
  output logic               norm_skipped,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int W  = COMP_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int MW = (W > 16) ? W : 16;
  localparam int AW = 2 * MW + 2;
  localparam int HW = AW / 2;
  localparam int NW = W + F + 1;
  localparam int KW = ((HW > F + 1) ? HW : F + 1) + 1;

  localparam logic signed [W-1:0]  CMAX_W = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0]  CMIN_W = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [MW-1:0] CMAX_M = {{(MW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [MW-1:0] CMIN_M = {{(MW-W+1){1'b1}}, {(W-1){1'b0}}};
  localparam logic signed [AW-1:0] CMAX_A = {{(AW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [AW-1:0] CMIN_A = {{(AW-W+1){1'b1}}, {(W-1){1'b0}}};
  localparam logic signed [AW-1:0] RND_A  = AW'(1) << (F - 1);
  localparam logic [NW-1:0]        CMAX_N = NW'(CMAX_W);
  localparam logic [NW-1:0]        HALF_N = NW'(1) << (W - 1);
  localparam logic [KW-1:0]        ONE_K  = KW'(1) << F;
  localparam logic                 ONE_CLIPS = (F > W - 2);
  localparam logic signed [W-1:0]  ONE_W  = ONE_CLIPS ? CMAX_W : (W'(1) << F);

  state_t state, state_next;

  logic signed [W-1:0]  quat [4];
  logic signed [W-1:0]  r    [4];
  logic signed [15:0]   opnd [4];
  logic [2:0]           func_q;
  logic [1:0]           comp;
  logic [1:0]           term;
  logic                 sat_q;
  logic                 skip_q;
  logic [TOL_W-1:0]     unit_tol;

  mul_ctl_t             mul_ctl;
  logic                 mul_done;
  logic [AW-1:0]        acc;
  logic                 sqrt_start;
  logic                 sqrt_done;
  logic [HW-1:0]        root;
  logic                 div_start;
  logic                 div_done;
  logic [NW-1:0]        quot;
  logic                 out_free;
  logic                 fin_load;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr == REG_UNIT_TOL) ? 32'(unit_tol) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_tol <= TOL_W'(1);
    end else if (psel && penable && pwrite && paddr == REG_UNIT_TOL) begin
      unit_tol <= pwdata[TOL_W-1:0];
    end
  end

  // Operand selection for the serial multiplier.
  logic [3:0]           tidx;
  logic signed [MW-1:0] av;
  logic signed [MW-1:0] bv;
  logic [MW-1:0]        ma;
  logic [MW-1:0]        mb;
  logic                 term_neg;

  assign tidx = {comp, term};

  always_comb begin
    case (func_t'(func_q))
      F_MUL_L: begin
        av = MW'(opnd[HAM_A[tidx]]);
        bv = MW'(quat[HAM_B[tidx]]);
        term_neg = HAM_NEG[tidx];
      end
      F_NORM: begin
        av = MW'(quat[term]);
        bv = MW'(quat[term]);
        term_neg = 1'b0;
      end
      default: begin
        av = MW'(quat[HAM_A[tidx]]);
        bv = MW'(opnd[HAM_B[tidx]]);
        term_neg = HAM_NEG[tidx];
      end
    endcase
    ma = av[MW-1] ? (~av + 1'b1) : av;
    mb = bv[MW-1] ? (~bv + 1'b1) : bv;
  end

  // Rounding and saturation of a finished dot product.
  logic signed [AW-1:0] rnd_sum;
  logic signed [AW-1:0] rnd_sh;
  logic signed [W-1:0]  rnd_v;
  logic                 rnd_clip;

  always_comb begin
    rnd_sum = $signed(acc) + RND_A;
    rnd_sh  = rnd_sum >>> F;
    rnd_clip = 1'b1;
    if (rnd_sh > CMAX_A) begin
      rnd_v = CMAX_W;
    end else if (rnd_sh < CMIN_A) begin
      rnd_v = CMIN_W;
    end else begin
      rnd_v = rnd_sh[W-1:0];
      rnd_clip = 1'b0;
    end
  end

  // Load and conjugate values, one per component.
  logic signed [W-1:0] load_v [4];
  logic [3:0]          load_clip;
  logic signed [W-1:0] conj_v [4];
  logic [3:0]          conj_clip;
  logic signed [MW-1:0] ox [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ox[i] = MW'(opnd[i]);
      load_clip[i] = 1'b1;
      if (ox[i] > CMAX_M) begin
        load_v[i] = CMAX_W;
      end else if (ox[i] < CMIN_M) begin
        load_v[i] = CMIN_W;
      end else begin
        load_v[i] = ox[i][W-1:0];
        load_clip[i] = 1'b0;
      end
      if (i < 3 && quat[i] == CMIN_W) begin
        conj_v[i] = CMAX_W;
        conj_clip[i] = 1'b1;
      end else if (i < 3) begin
        conj_v[i] = -quat[i];
        conj_clip[i] = 1'b0;
      end else begin
        conj_v[i] = quat[i];
        conj_clip[i] = 1'b0;
      end
    end
  end

  // Unit test for normalize and the division set-up.
  logic [KW-1:0]       len_k;
  logic [KW-1:0]       unit_dist;
  logic                skip_norm;
  logic signed [W-1:0] qc;
  logic [W-1:0]        mq;
  logic [NW-1:0]       div_num;
  logic signed [W-1:0] div_v;
  logic                div_clip;

  always_comb begin
    len_k = KW'(root);
    unit_dist = (len_k > ONE_K) ? (len_k - ONE_K) : (ONE_K - len_k);
    skip_norm = (root == '0) || (unit_dist <= KW'(unit_tol));
    qc = quat[comp];
    mq = qc[W-1] ? (~qc + 1'b1) : qc;
    div_num = (NW'(mq) << F) + NW'(root >> 1);
    div_clip = 1'b0;
    if (qc[W-1]) begin
      if (quot > HALF_N) begin
        div_v = CMIN_W;
        div_clip = 1'b1;
      end else begin
        div_v = ~quot[W-1:0] + 1'b1;
      end
    end else begin
      if (quot > CMAX_N) begin
        div_v = CMAX_W;
        div_clip = 1'b1;
      end else begin
        div_v = quot[W-1:0];
      end
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and unit strobes.
  always_comb begin
    state_next = state;
    mul_ctl    = '0;
    mul_ctl.neg = av[MW-1] ^ bv[MW-1] ^ term_neg;
    sqrt_start = 1'b0;
    div_start  = 1'b0;
    fin_load   = 1'b0;
    out_free   = !out_valid || !out_stall;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (func_t'(func_q) inside {F_MUL_R, F_MUL_L}) begin
          mul_ctl.clear = 1'b1;
          state_next = S_MUL_GO;
        end else if (func_t'(func_q) == F_NORM) begin
          mul_ctl.clear = 1'b1;
          state_next = S_SQ_GO;
        end else begin
          state_next = S_FIN;
        end
      end
      S_MUL_GO: begin
        mul_ctl.start = 1'b1;
        state_next = S_MUL_WAIT;
      end
      S_MUL_WAIT: begin
        if (mul_done) begin
          if (term == 2'd3) begin
            mul_ctl.clear = 1'b1;
            state_next = (comp == 2'd3) ? S_FIN : S_MUL_GO;
          end else begin
            state_next = S_MUL_GO;
          end
        end
      end
      S_SQ_GO: begin
        mul_ctl.start = 1'b1;
        state_next = S_SQ_WAIT;
      end
      S_SQ_WAIT: begin
        if (mul_done) begin
          state_next = (term == 2'd3) ? S_SQRT_GO : S_SQ_GO;
        end
      end
      S_SQRT_GO: begin
        sqrt_start = 1'b1;
        state_next = S_SQRT_WAIT;
      end
      S_SQRT_WAIT: begin
        if (sqrt_done) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = skip_norm ? S_FIN : S_DIV_GO;
      end
      S_DIV_GO: begin
        div_start = 1'b1;
        state_next = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          state_next = (comp == 2'd3) ? S_FIN : S_DIV_GO;
        end
      end
      S_FIN: begin
        if (out_free) begin
          fin_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign in_stall = (state != S_IDLE);

  // Stored quaternion and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      quat[0]   <= '0;
      quat[1]   <= '0;
      quat[2]   <= '0;
      quat[3]   <= ONE_W;
      out_valid <= 1'b0;
      comp      <= '0;
      term      <= '0;
    end else begin
      if (fin_load) begin
        for (int i = 0; i < 4; i++) begin
          quat[i] <= r[i];
        end
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_EXEC: begin
          comp <= '0;
          term <= '0;
        end
        S_MUL_WAIT: begin
          if (mul_done) begin
            term <= term + 2'd1;
            if (term == 2'd3) begin
              comp <= comp + 2'd1;
            end
          end
        end
        S_SQ_WAIT: begin
          if (mul_done) begin
            term <= term + 2'd1;
          end
        end
        S_CHECK: begin
          comp <= '0;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            comp <= comp + 2'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Request capture, working result and result register.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      func_q  <= func;
      opnd[0] <= in_x;
      opnd[1] <= in_y;
      opnd[2] <= in_z;
      opnd[3] <= in_w;
    end
    case (state)
      S_EXEC: begin
        sat_q  <= 1'b0;
        skip_q <= 1'b0;
        case (func_t'(func_q))
          F_LOAD: begin
            for (int i = 0; i < 4; i++) begin
              r[i] <= load_v[i];
            end
            sat_q <= |load_clip;
          end
          F_IDENT: begin
            r[0]  <= '0;
            r[1]  <= '0;
            r[2]  <= '0;
            r[3]  <= ONE_W;
            sat_q <= ONE_CLIPS;
          end
          F_CONJ: begin
            for (int i = 0; i < 4; i++) begin
              r[i] <= conj_v[i];
            end
            sat_q <= |conj_clip;
          end
          default: begin
            for (int i = 0; i < 4; i++) begin
              r[i] <= quat[i];
            end
          end
        endcase
      end
      S_MUL_WAIT: begin
        if (mul_done && term == 2'd3) begin
          r[comp] <= rnd_v;
          sat_q   <= sat_q | rnd_clip;
        end
      end
      S_CHECK: begin
        skip_q <= skip_norm;
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          r[comp] <= div_v;
          sat_q   <= sat_q | div_clip;
        end
      end
      default: begin
      end
    endcase
    if (fin_load) begin
      out_x        <= 16'(r[0]);
      out_y        <= 16'(r[1]);
      out_z        <= 16'(r[2]);
      out_w        <= 16'(r[3]);
      saturated    <= sat_q;
      norm_skipped <= skip_q;
    end
  end

  // Serial arithmetic units.
  qau_mul_acc #(.MW(MW), .AW(AW)) u_mul (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mul_ctl),
    .ma   (ma),
    .mb   (mb),
    .done (mul_done),
    .acc  (acc)
  );

  qau_sqrt #(.RW(AW)) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (acc),
    .done     (sqrt_done),
    .root     (root)
  );

  qau_div #(.NW(NW), .DW(HW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (root),
    .done  (div_done),
    .quot  (quot)
  );

  // Checks on the sequencer.
  a_mul_done_ctx: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == S_MUL_WAIT || state == S_SQ_WAIT))
    else $error("multiplier finished outside a multiply wait");

  a_div_done_ctx: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV_WAIT))
    else $error("divider finished outside the divide wait");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_EXEC))
    else $error("accepted request did not start execution");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !(saturated && norm_skipped))
    else $error("skipped normalize reported saturation");

endmodule
